// ----- src/stld_pkg.sv -----
// ---------------------------------------------------------------------------
// stld_pkg: shared types and constants of the sequence-triple layer decoder
// Field widths, operation, result and relation codes, and the write-enable
// group that the load checker hands to the sequence store.
// ---------------------------------------------------------------------------
`default_nettype none
package stld_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int ID_W           = 5;
  localparam int CNT_W          = 6;
  localparam int NL_W           = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic KIND_LAYER = 1'b0;
  localparam logic KIND_REL   = 1'b1;

  localparam logic [1:0] REL_LEFT    = 2'd0;
  localparam logic [1:0] REL_BELOW   = 2'd1;
  localparam logic [1:0] REL_LOWER   = 2'd2;
  localparam logic [1:0] REL_INVALID = 2'd3;

  typedef struct packed {
    logic we_order;
    logic we_first;
    logic we_second;
    logic we_third;
  } wr_t;

endpackage
`default_nettype wire

// ----- src/stld_check.sv -----
// ---------------------------------------------------------------------------
// stld_check: load bookkeeping
// Tracks the seen flags of the three sequences, the count of accepted
// positions, the fault flag and the largest id of the current load, and
// decides which memory writes a load word makes and whether it is valid.
// ---------------------------------------------------------------------------
`default_nettype none
module stld_check #(
  parameter int MAX_BLOCKS = stld_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [stld_pkg::ID_W-1:0]   position,
  input  wire logic [stld_pkg::ID_W-1:0]   first_value,
  input  wire logic [stld_pkg::ID_W-1:0]   second_value,
  input  wire logic [stld_pkg::ID_W-1:0]   third_value,
  output stld_pkg::wr_t                    wr,
  output logic                             ok_now,
  output logic [stld_pkg::CNT_W-1:0]       entry_count
);

  localparam int AW = $clog2(MAX_BLOCKS);

  logic [MAX_BLOCKS-1:0] seen1, seen2, seen3;
  logic [MAX_BLOCKS-1:0] seen1_next, seen2_next, seen3_next;
  logic                  fault, fault_next;
  logic [stld_pkg::ID_W-1:0]  max_id, max_next;
  logic [stld_pkg::CNT_W-1:0] cnt_next, base_cnt;
  logic                  restart, inorder, f_ok, s_ok, t_ok, base_fault;

  always_comb begin
    restart    = (position == '0);
    base_cnt   = restart ? '0 : entry_count;
    base_fault = restart ? 1'b0 : fault;
    seen1_next = restart ? '0 : seen1;
    seen2_next = restart ? '0 : seen2;
    seen3_next = restart ? '0 : seen3;
    max_next   = restart ? '0 : max_id;
    inorder = (stld_pkg::CNT_W'(position) == base_cnt) && (int'(position) < MAX_BLOCKS);
    f_ok = (int'(first_value) < MAX_BLOCKS) && !seen1_next[AW'(first_value)];
    s_ok = (int'(second_value) < MAX_BLOCKS) && !seen2_next[AW'(second_value)];
    t_ok = (int'(third_value) < MAX_BLOCKS) && !seen3_next[AW'(third_value)];
    wr.we_order  = load && inorder && f_ok;
    wr.we_first  = load && inorder && f_ok;
    wr.we_second = load && inorder && s_ok;
    wr.we_third  = load && inorder && t_ok;
    if (inorder && f_ok) begin
      seen1_next[AW'(first_value)] = 1'b1;
    end
    if (inorder && s_ok) begin
      seen2_next[AW'(second_value)] = 1'b1;
    end
    if (inorder && t_ok) begin
      seen3_next[AW'(third_value)] = 1'b1;
    end
    if (inorder) begin
      if (first_value > max_next) max_next = first_value;
      if (second_value > max_next) max_next = second_value;
      if (third_value > max_next) max_next = third_value;
    end
    fault_next = base_fault || !inorder || !(f_ok && s_ok && t_ok);
    cnt_next   = base_cnt + stld_pkg::CNT_W'(inorder);
    // With no fault, n distinct ids per sequence that all lie below n
    // cover 0..n-1 exactly.
    ok_now = !fault_next && (cnt_next == stld_pkg::CNT_W'(position) + 1'b1) &&
             (max_next <= position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen1       <= '0;
      seen2       <= '0;
      seen3       <= '0;
      fault       <= 1'b0;
      max_id      <= '0;
      entry_count <= '0;
    end else if (load) begin
      seen1       <= seen1_next;
      seen2       <= seen2_next;
      seen3       <= seen3_next;
      fault       <= fault_next;
      max_id      <= max_next;
      entry_count <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/stld_store.sv -----
// ---------------------------------------------------------------------------
// stld_store: sequence store
// Holds the first sequence by position and the rank of every block in the
// three sequences, each in a synchronous one-write, one-read memory.
// ---------------------------------------------------------------------------
`default_nettype none
module stld_store #(
  parameter int MAX_BLOCKS = stld_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                              clk,
  input  wire stld_pkg::wr_t                     wr,
  input  wire logic [stld_pkg::ID_W-1:0]         position,
  input  wire logic [stld_pkg::ID_W-1:0]         first_value,
  input  wire logic [stld_pkg::ID_W-1:0]         second_value,
  input  wire logic [stld_pkg::ID_W-1:0]         third_value,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0]     order_ra,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0]     rank_ra,
  output logic [stld_pkg::ID_W-1:0]              order_q,
  output logic [stld_pkg::ID_W-1:0]              r1_q,
  output logic [stld_pkg::ID_W-1:0]              r2_q,
  output logic [stld_pkg::ID_W-1:0]              r3_q
);

  localparam int AW = $clog2(MAX_BLOCKS);

  logic [stld_pkg::ID_W-1:0] order_mem [MAX_BLOCKS];
  logic [stld_pkg::ID_W-1:0] r1_mem    [MAX_BLOCKS];
  logic [stld_pkg::ID_W-1:0] r2_mem    [MAX_BLOCKS];
  logic [stld_pkg::ID_W-1:0] r3_mem    [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.we_order) order_mem[AW'(position)] <= first_value;
    order_q <= order_mem[order_ra];
  end

  always_ff @(posedge clk) begin
    if (wr.we_first) r1_mem[AW'(first_value)] <= position;
    r1_q <= r1_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (wr.we_second) r2_mem[AW'(second_value)] <= position;
    r2_q <= r2_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (wr.we_third) r3_mem[AW'(third_value)] <= position;
    r3_q <= r3_mem[rank_ra];
  end

endmodule
`default_nettype wire

// ----- src/sequence_triple_layer_decoder.sv -----
// ---------------------------------------------------------------------------
// sequence_triple_layer_decoder: layer decode of a sequence triple
// Loads three block sequences, checks them, assigns each block a layer and
// answers pair relation queries.
//
// Channel  Direction  Handshake            Payload
// command  in         start / busy         op, position, *_value, load_last,
//                                          query_block_a, query_block_b
// config   in         cfg_valid/cfg_ready  cfg_data (num_layers)
// result   out        strobe               kind, block_id, layer_index,
//                                          other_block, relation,
//                                          perm_valid, result_last
//
// A load that is not the last and an invalid query leave the block idle.
// A valid query makes two rank memory reads, then the compare.
// A last load of n blocks runs the layer pass over the rank memories when
// valid, then stays busy for the layer reads; the last of the n layer
// results shows in the first idle cycle.
// rst is synchronous; no clearing pass is needed. Results are not stalled.
// ---------------------------------------------------------------------------
`default_nettype none
module sequence_triple_layer_decoder #(
  parameter int MAX_BLOCKS = stld_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        op,
  input  wire logic [stld_pkg::ID_W-1:0]   position,
  input  wire logic [stld_pkg::ID_W-1:0]   first_value,
  input  wire logic [stld_pkg::ID_W-1:0]   second_value,
  input  wire logic [stld_pkg::ID_W-1:0]   third_value,
  input  wire logic                        load_last,
  input  wire logic [stld_pkg::ID_W-1:0]   query_block_a,
  input  wire logic [stld_pkg::ID_W-1:0]   query_block_b,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stld_pkg::NL_W-1:0]   cfg_data,
  output logic                             strobe,
  output logic                             kind,
  output logic [stld_pkg::ID_W-1:0]        block_id,
  output logic [stld_pkg::ID_W-1:0]        layer_index,
  output logic [stld_pkg::ID_W-1:0]        other_block,
  output logic [1:0]                       relation,
  output logic                             perm_valid,
  output logic                             result_last
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = stld_pkg::ID_W;
  localparam int CW = stld_pkg::CNT_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_BORD  = 13'b0000000000010,
    S_BRANK = 13'b0000000000100,
    S_BLAT  = 13'b0000000001000,
    S_AORD  = 13'b0000000010000,
    S_ARANK = 13'b0000000100000,
    S_ACMP  = 13'b0000001000000,
    S_WR    = 13'b0000010000000,
    S_EMIT  = 13'b0000100000000,
    S_DRAIN = 13'b0001000000000,
    S_QB    = 13'b0010000000000,
    S_QCMP  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  logic accept, load, query, q_bad, ok_now, perm_ok;
  stld_pkg::wr_t wr;
  logic [CW-1:0] entry_count, n;
  logic [IW-1:0] ib, ia, eid, b_id, rb2, rb3, qa, qb, qr1, qr2, qr3;
  logic [CW-1:0] lay, cand, top_l, lay_c;
  logic [AW-1:0] order_ra, rank_ra, layer_ra;
  logic [IW-1:0] order_q, r1_q, r2_q, r3_q, layer_q;
  logic [IW-1:0] layer_mem [MAX_BLOCKS];
  logic [stld_pkg::NL_W-1:0] num_layers;
  logic e_v, e_last;
  logic [IW-1:0] e_id;
  logic swap;
  logic [IW-1:0] e2, l2, e3, l3;
  logic [1:0] rel_c;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start && !busy;
  assign load      = accept && (op == stld_pkg::OP_LOAD);
  assign query     = accept && (op == stld_pkg::OP_QUERY);
  assign q_bad = !perm_ok || (CW'(query_block_a) >= entry_count) ||
                 (CW'(query_block_b) >= entry_count) || (query_block_a == query_block_b);

  stld_check #(.MAX_BLOCKS(MAX_BLOCKS)) u_check (
    .clk, .rst, .load, .position, .first_value, .second_value, .third_value,
    .wr, .ok_now, .entry_count
  );

  stld_store #(.MAX_BLOCKS(MAX_BLOCKS)) u_store (
    .clk, .wr, .position, .first_value, .second_value, .third_value,
    .order_ra, .rank_ra, .order_q, .r1_q, .r2_q, .r3_q
  );

  always_comb begin
    order_ra = AW'(ia);
    rank_ra  = '0;
    layer_ra = AW'(order_q);
    unique case (state)
      S_IDLE:  rank_ra = AW'(query_block_a);
      S_BORD:  order_ra = AW'(ib);
      S_BRANK: rank_ra = AW'(order_q);
      S_ARANK: rank_ra = AW'(order_q);
      S_EMIT:  layer_ra = AW'(eid);
      S_QB:    rank_ra = AW'(qb);
      default: rank_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_WR) layer_mem[AW'(b_id)] <= lay_c[IW-1:0];
    layer_q <= layer_mem[layer_ra];
  end

  always_comb begin
    top_l = (num_layers == '0) ? '0 : num_layers - 1'b1;
    lay_c = (lay > top_l) ? top_l : lay;
    cand  = CW'(layer_q) + 1'b1;
    swap  = qr1 > r1_q;
    e2 = swap ? r2_q : qr2;
    l2 = swap ? qr2 : r2_q;
    e3 = swap ? r3_q : qr3;
    l3 = swap ? qr3 : r3_q;
    if (e2 < l2) rel_c = stld_pkg::REL_LEFT;
    else if (e3 < l3) rel_c = stld_pkg::REL_BELOW;
    else rel_c = stld_pkg::REL_LOWER;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (load && load_last) state_next = ok_now ? S_BORD : S_EMIT;
        else if (query && !q_bad) state_next = S_QB;
      end
      S_BORD:  state_next = S_BRANK;
      S_BRANK: state_next = S_BLAT;
      S_BLAT:  state_next = (ib == '0) ? S_WR : S_AORD;
      S_AORD:  state_next = S_ARANK;
      S_ARANK: state_next = S_ACMP;
      S_ACMP:  state_next = (ia + 1'b1 == ib) ? S_WR : S_AORD;
      S_WR:    state_next = (CW'(ib) + 1'b1 == n) ? S_EMIT : S_BORD;
      S_EMIT:  state_next = (CW'(eid) + 1'b1 == n) ? S_DRAIN : S_EMIT;
      S_DRAIN: state_next = S_IDLE;
      S_QB:    state_next = S_QCMP;
      S_QCMP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      perm_ok    <= 1'b0;
      num_layers <= stld_pkg::NL_W'(1);
      e_v        <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state <= state_next;
      e_v   <= (state == S_EMIT);
      if (cfg_valid && cfg_ready) num_layers <= cfg_data;
      if (load) perm_ok <= load_last && ok_now;
      strobe <= e_v || (query && q_bad) || (state == S_QCMP);
    end
  end

  always_ff @(posedge clk) begin
    e_id   <= eid;
    e_last <= (CW'(eid) + 1'b1 == n);
    if (load && load_last) begin
      n   <= CW'(position) + 1'b1;
      ib  <= '0;
      eid <= '0;
    end
    if (query) begin
      qa <= query_block_a;
      qb <= query_block_b;
    end
    unique case (state)
      S_BRANK: b_id <= order_q;
      S_BLAT: begin
        rb2 <= r2_q;
        rb3 <= r3_q;
        lay <= '0;
        ia  <= '0;
      end
      S_ACMP: begin
        // An earlier block that follows this one in both other sequences
        // pushes it one layer above its own.
        if ((r2_q > rb2) && (r3_q > rb3) && (cand > lay)) lay <= cand;
        ia <= ia + 1'b1;
      end
      S_WR:   ib <= ib + 1'b1;
      S_EMIT: eid <= eid + 1'b1;
      S_QB: begin
        qr1 <= r1_q;
        qr2 <= r2_q;
        qr3 <= r3_q;
      end
      default: begin
      end
    endcase

    if (e_v) begin
      kind        <= stld_pkg::KIND_LAYER;
      block_id    <= e_id;
      layer_index <= perm_ok ? layer_q : '0;
      other_block <= '0;
      relation    <= stld_pkg::REL_LEFT;
      perm_valid  <= perm_ok;
      result_last <= e_last;
    end else if (query && q_bad) begin
      kind        <= stld_pkg::KIND_REL;
      block_id    <= query_block_a;
      layer_index <= '0;
      other_block <= query_block_b;
      relation    <= stld_pkg::REL_INVALID;
      perm_valid  <= perm_ok;
      result_last <= 1'b1;
    end else if (state == S_QCMP) begin
      kind        <= stld_pkg::KIND_REL;
      block_id    <= swap ? qb : qa;
      layer_index <= '0;
      other_block <= swap ? qa : qb;
      relation    <= rel_c;
      perm_valid  <= perm_ok;
      result_last <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- src/stld_checker.sv -----
// ---------------------------------------------------------------------------
// stld_checker: port-level checks of the layer decoder
// Watches the command and result ports and checks result grouping and the
// fixed fields of each result kind.
// ---------------------------------------------------------------------------
`default_nettype none
module stld_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      op,
  input wire logic                      load_last,
  input wire logic                      strobe,
  input wire logic                      kind,
  input wire logic [stld_pkg::ID_W-1:0] other_block,
  input wire logic [1:0]                relation,
  input wire logic                      perm_valid,
  input wire logic                      result_last
);

  // Layer results of one load come in an unbroken run.
  a_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !result_last |=> strobe)
    else $error("layer result run broken");

  a_rel_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == stld_pkg::KIND_REL) |-> result_last)
    else $error("relation result not marked last");

  a_layer_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == stld_pkg::KIND_LAYER) |->
      (relation == stld_pkg::REL_LEFT) && (other_block == '0))
    else $error("layer result carries pair fields");

  a_rel_valid: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == stld_pkg::KIND_REL) && (relation != stld_pkg::REL_INVALID)
      |-> perm_valid)
    else $error("relation reported without a valid load");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == stld_pkg::OP_LOAD) && !load_last |=> !strobe)
    else $error("result after a load that is not the last");

endmodule

bind sequence_triple_layer_decoder stld_checker u_stld_checker (.*);
`default_nettype wire

// ----- bench/tb_sequence_triple_layer_decoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sequence_triple_layer_decoder: self-checking bench of the layer decoder
// Sends a directed table of loads and queries, then random sequence triples
// (mostly well formed, some broken) with pair queries and layer-count changes.
// Every result word is checked field by field against a predictor or table row.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_sequence_triple_layer_decoder;

  localparam int NB       = 32;
  localparam int DOG_MAX  = 20000;
  localparam int N_ITEMS  = 410;

  typedef struct {
    logic       op;
    logic [4:0] pos;
    logic [4:0] fv;
    logic [4:0] sv;
    logic [4:0] tv;
    logic       last;
    logic [4:0] qa;
    logic [4:0] qb;
  } cmd_t;

  typedef struct {
    logic       kind;
    logic [4:0] blk;
    logic [4:0] lay;
    logic [4:0] oth;
    logic [1:0] rel;
    logic       pv;
    logic       lst;
  } res_t;

  // Directed row: typed is set where the result word is known by inspection.
  typedef struct {
    cmd_t c;
    logic typed;
    res_t r;
  } row_t;

  logic       clk = 0;
  logic       rst = 1;
  logic       start = 0;
  logic       busy;
  logic       op = 0;
  logic [4:0] position = 0, first_value = 0, second_value = 0, third_value = 0;
  logic       load_last = 0;
  logic [4:0] query_block_a = 0, query_block_b = 0;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [5:0] cfg_data = 0;
  logic       strobe, kind, perm_valid, result_last;
  logic [4:0] block_id, layer_index, other_block;
  logic [1:0] relation;

  sequence_triple_layer_decoder DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .position(position), .first_value(first_value),
    .second_value(second_value), .third_value(third_value),
    .load_last(load_last), .query_block_a(query_block_a),
    .query_block_b(query_block_b), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe),
    .kind(kind), .block_id(block_id), .layer_index(layer_index),
    .other_block(other_block), .relation(relation),
    .perm_valid(perm_valid), .result_last(result_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state.
  logic [4:0] seq_order [NB];
  logic [4:0] pos_first [NB];
  logic [4:0] pos_second [NB];
  logic [4:0] pos_third [NB];
  logic [4:0] layer_of [NB];
  logic [2:0] seen [NB];
  int unsigned loaded;
  logic        triple_ok;
  logic        fault;
  logic [5:0]  layer_count;

  res_t pending_words[$];
  int   failures = 0;
  int   items = 0;
  int   words_seen = 0;
  int   good_loads = 0;
  int   bad_loads = 0;
  bit   no_gaps = 0;

  function automatic res_t word(logic k, logic [4:0] b, logic [4:0] l,
                                logic [4:0] o, logic [1:0] r, logic lst);
    res_t w;
    w.kind = k; w.blk = b; w.lay = l; w.oth = o; w.rel = r;
    w.pv = triple_ok; w.lst = lst;
    return w;
  endfunction

  function automatic void note_id(int id, int bitpos, int p, ref logic [4:0] rk [NB]);
    if (seen[id][bitpos]) begin
      fault = 1;
    end else begin
      seen[id][bitpos] = 1;
      rk[id] = p[4:0];
    end
  endfunction

  // Advances the decoder state by one accepted word and queues its results.
  function automatic void predict_layers(cmd_t c, ref res_t outq[$]);
    int n, top, lay, b, a;
    logic ok;
    if (c.op == stld_pkg::OP_LOAD) begin
      triple_ok = 0;
      if (c.pos == 0) begin
        foreach (seen[i]) seen[i] = '0;
        loaded = 0;
        fault = 0;
      end
      if (c.pos != loaded) begin
        fault = 1;
      end else begin
        if (seen[c.fv][0]) fault = 1;
        else seq_order[c.pos] = c.fv;
        note_id(c.fv, 0, c.pos, pos_first);
        note_id(c.sv, 1, c.pos, pos_second);
        note_id(c.tv, 2, c.pos, pos_third);
        loaded++;
      end
      if (!c.last) return;
      n = c.pos + 1;
      ok = !fault && loaded == n;
      for (int id = 0; id < n; id++) if (seen[id] != 3'b111) ok = 0;
      triple_ok = ok;
      if (ok) begin
        good_loads++;
        top = (layer_count == 0) ? 0 : layer_count - 1;
        for (int ib = 0; ib < n; ib++) begin
          b = seq_order[ib];
          lay = 0;
          for (int ia = 0; ia < ib; ia++) begin
            a = seq_order[ia];
            if (pos_second[a] > pos_second[b] && pos_third[a] > pos_third[b] &&
                layer_of[a] + 1 > lay)
              lay = layer_of[a] + 1;
          end
          if (lay > top) lay = top;
          layer_of[b] = lay[4:0];
        end
      end else begin
        bad_loads++;
        for (int id = 0; id < n; id++) layer_of[id] = '0;
      end
      for (int id = 0; id < n; id++)
        outq = {outq, word(stld_pkg::KIND_LAYER, id[4:0], layer_of[id], '0,
                           stld_pkg::REL_LEFT, id + 1 == n)};
    end else begin
      if (!triple_ok || c.qa >= loaded || c.qb >= loaded || c.qa == c.qb) begin
        outq = {outq, word(stld_pkg::KIND_REL, c.qa, '0, c.qb, stld_pkg::REL_INVALID,
                           1'b1)};
      end else begin
        logic [4:0] e, l;
        logic [1:0] r;
        e = c.qa; l = c.qb;
        if (pos_first[c.qa] > pos_first[c.qb]) begin
          e = c.qb; l = c.qa;
        end
        if (pos_second[e] < pos_second[l]) r = stld_pkg::REL_LEFT;
        else if (pos_third[e] < pos_third[l]) r = stld_pkg::REL_BELOW;
        else r = stld_pkg::REL_LOWER;
        outq = {outq, word(stld_pkg::KIND_REL, e, '0, l, r, 1'b1)};
      end
    end
  endfunction

  // Result checker: the receiver never stalls, so every strobe is a word.
  always @(posedge clk) begin
    res_t e;
    if (!rst && strobe) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        failures++;
        $error("result word with nothing expected (block_id %0d)", block_id);
      end else begin
        e = pending_words.pop_front();
        if (kind !== e.kind) begin
          failures++; $error("kind: expected %0d, got %0d", e.kind, kind);
        end
        if (block_id !== e.blk) begin
          failures++; $error("block_id: expected %0d, got %0d", e.blk, block_id);
        end
        if (layer_index !== e.lay) begin
          failures++;
          $error("layer_index: expected %0d, got %0d", e.lay, layer_index);
        end
        if (other_block !== e.oth) begin
          failures++;
          $error("other_block: expected %0d, got %0d", e.oth, other_block);
        end
        if (relation !== e.rel) begin
          failures++; $error("relation: expected %0d, got %0d", e.rel, relation);
        end
        if (perm_valid !== e.pv) begin
          failures++;
          $error("perm_valid: expected %0d, got %0d", e.pv, perm_valid);
        end
        if (result_last !== e.lst) begin
          failures++;
          $error("result_last: expected %0d, got %0d", e.lst, result_last);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= DOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(cmd_t c, logic typed, res_t r);
    res_t tmp[$];
    if (!no_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    @(negedge clk);
    op = c.op; position = c.pos; first_value = c.fv; second_value = c.sv;
    third_value = c.tv; load_last = c.last;
    query_block_a = c.qa; query_block_b = c.qb;
    start = 1;
    do @(posedge clk); while (busy);
    items++;
    predict_layers(c, tmp);
    if (typed) pending_words = {pending_words, r};
    else foreach (tmp[i]) pending_words = {pending_words, tmp[i]};
  endtask

  // Waits until the block is idle, then writes the layer count.
  task automatic set_layers(logic [5:0] v);
    @(negedge clk);
    start = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    layer_count = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic cmd_t ld(int p, int f, int s, int t, bit lst);
    cmd_t c;
    c.op = stld_pkg::OP_LOAD; c.pos = 5'(p); c.fv = 5'(f); c.sv = 5'(s);
    c.tv = 5'(t); c.last = lst;
    c.qa = 5'($urandom); c.qb = 5'($urandom);
    return c;
  endfunction

  function automatic cmd_t qy(int a, int b);
    cmd_t c;
    c = ld(0, 0, 0, 0, 0);
    c.op = stld_pkg::OP_QUERY; c.qa = 5'(a); c.qb = 5'(b);
    c.pos = 5'($urandom); c.fv = 5'($urandom); c.sv = 5'($urandom);
    c.tv = 5'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  function automatic row_t plain(cmd_t c);
    row_t w;
    w.c = c; w.typed = 0; w.r = '{default: '0};
    return w;
  endfunction

  function automatic row_t fixed(cmd_t c, logic k, int b, int l, int o,
                                 logic [1:0] r, logic pv);
    row_t w;
    w.c = c; w.typed = 1;
    w.r = '{kind: k, blk: 5'(b), lay: 5'(l), oth: 5'(o), rel: r, pv: pv, lst: 1'b1};
    return w;
  endfunction

  // Shuffled 0..n-1, or its reverse with a few swaps to build deep chains.
  function automatic void make_perm(int n, bit deep, ref int p [NB]);
    int j, x;
    for (int i = 0; i < n; i++) p[i] = deep ? n - 1 - i : i;
    for (int k = 0; k < (deep ? $urandom_range(0, 2) : n); k++) begin
      j = $urandom_range(0, n - 1);
      x = $urandom_range(0, n - 1);
      {p[j], p[x]} = {p[x], p[j]};
    end
  endfunction

  initial begin
    row_t table_rows[$];
    int pf [NB], ps [NB], pt [NB];
    int n, seqs, skip_at, dup_at;
    bit deep;
    logic [5:0] settings [7] = '{6'd32, 6'd0, 6'd63, 6'd2, 6'd3, 6'd1, 6'd5};

    loaded = 0; triple_ok = 0; fault = 0; layer_count = 6'd1;
    foreach (seen[i]) seen[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    table_rows = {table_rows, fixed(qy(0, 1), stld_pkg::KIND_REL, 0, 0, 1,
                                    stld_pkg::REL_INVALID, 0)};
    table_rows = {table_rows, fixed(ld(0, 0, 0, 0, 1), stld_pkg::KIND_LAYER, 0, 0, 0,
                                    stld_pkg::REL_LEFT, 1)};
    table_rows = {table_rows, fixed(qy(0, 0), stld_pkg::KIND_REL, 0, 0, 0,
                                    stld_pkg::REL_INVALID, 1)};
    // Fully stacked triple: each block sits above all earlier ones.
    table_rows = {table_rows, plain(ld(0, 0, 2, 2, 0))};
    table_rows = {table_rows, plain(ld(1, 1, 1, 1, 0))};
    table_rows = {table_rows, fixed(qy(1, 0), stld_pkg::KIND_REL, 1, 0, 0,
                                    stld_pkg::REL_INVALID, 0)};
    table_rows = {table_rows, plain(ld(2, 2, 0, 0, 1))};
    table_rows = {table_rows, plain(qy(2, 0))};
    table_rows = {table_rows, fixed(qy(1, 31), stld_pkg::KIND_REL, 1, 0, 31,
                                    stld_pkg::REL_INVALID, 1)};
    // One on top of the other, then side by side.
    table_rows = {table_rows, plain(ld(0, 1, 0, 0, 0))};
    table_rows = {table_rows, plain(ld(1, 0, 1, 1, 1))};
    table_rows = {table_rows, plain(qy(0, 1))};
    table_rows = {table_rows, plain(ld(0, 0, 1, 0, 0))};
    table_rows = {table_rows, plain(ld(1, 1, 0, 1, 1))};
    table_rows = {table_rows, plain(qy(1, 0))};
    // Broken loads: duplicate id, skipped position, id outside the count.
    table_rows = {table_rows, plain(ld(0, 31, 0, 0, 0))};
    table_rows = {table_rows, plain(ld(1, 31, 1, 1, 1))};
    table_rows = {table_rows, plain(ld(0, 0, 0, 0, 0))};
    table_rows = {table_rows, plain(ld(2, 1, 1, 1, 1))};
    table_rows = {table_rows, plain(ld(0, 0, 31, 0, 0))};
    table_rows = {table_rows, plain(ld(1, 1, 1, 1, 1))};
    table_rows = {table_rows, fixed(qy(0, 1), stld_pkg::KIND_REL, 0, 0, 1,
                                    stld_pkg::REL_INVALID, 0)};
    table_rows = {table_rows, plain(ld(31, 3, 4, 5, 1))};

    foreach (table_rows[i]) send(table_rows[i].c, table_rows[i].typed, table_rows[i].r);

    seqs = 0;
    while (items < N_ITEMS) begin
      if (items > N_ITEMS - 60) no_gaps = 1;
      if (seqs % 8 == 0 && !no_gaps) begin
        set_layers(seqs / 8 < 7 ? settings[seqs / 8] : 6'($urandom_range(0, 63)));
      end
      seqs++;
      n = ($urandom_range(0, 11) == 0) ? 32 : $urandom_range(1, 8);
      deep = $urandom_range(0, 1);
      make_perm(n, 0, pf);
      make_perm(n, deep, ps);
      make_perm(n, deep, pt);
      skip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
      dup_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == skip_at) continue;
        if (i == dup_at) begin
          case ($urandom_range(0, 2))
            0: pf[i] = $urandom;
            1: ps[i] = $urandom;
            default: pt[i] = $urandom;
          endcase
        end
        send(ld(i, pf[i], ps[i], pt[i], i == n - 1), 0, '{default: '0});
      end
      // Pair queries, mostly on blocks of the current load.
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 5) == 0) send(qy($urandom, $urandom), 0, '{default: '0});
        else send(qy($urandom_range(0, n - 1), $urandom_range(0, n - 1)), 0,
                  '{default: '0});
      end
      if ($urandom_range(0, 15) == 0)
        send(ld($urandom, $urandom, $urandom, $urandom, 1'($urandom)), 0,
             '{default: '0});
    end

    @(negedge clk);
    start = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d command words over %0d sequence loads: %0d valid, %0d rejected.",
             items, good_loads + bad_loads, good_loads, bad_loads);
    $display("Checked %0d result words at several layer counts.", words_seen);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
